### hw/rtl/eos_pkg.sv
package eos_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int QUO_BITS      = 32;
  localparam int NUM_ANGLES    = 5;
  localparam int LATENCY       = CORDIC_STAGES + 42;

  localparam logic [2:0] REG_COS_IOTA       = 3'd0;
  localparam logic [2:0] REG_SOURCE_AZIMUTH = 3'd1;
  localparam logic [2:0] REG_PLUS_RESPONSE  = 3'd2;
  localparam logic [2:0] REG_CROSS_RESPONSE = 3'd3;
  localparam logic [2:0] REG_REF_SEMILATUS  = 3'd4;

  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [39:0] ONE_Q30   = 40'sd1073741824;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic [1:0]         q;
  } rot_t;

  typedef struct packed {
    logic signed [39:0] c;
    logic signed [39:0] s;
  } trig_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] d;
    logic [31:0] quo;
    logic        neg;
    logic        sat;
  } dvd_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // nearest quadrant removed, residual in [-1/8, 1/8) turn
  function automatic rot_t rot_init(input logic [31:0] ang);
    rot_t        r;
    logic [31:0] sum;
    logic [31:0] res;
    sum = ang + 32'h20000000;
    r.q = sum[31:30];
    res = ang - {r.q, 30'b0};
    r.x = CORDIC_X0;
    r.y = '0;
    r.z = $signed(res);
    return r;
  endfunction

  function automatic trig_t rot_out(input rot_t r);
    trig_t t;
    unique case (r.q)
      2'd0: begin
        t.c = 40'(r.x);
        t.s = 40'(r.y);
      end
      2'd1: begin
        t.c = -40'(r.y);
        t.s = 40'(r.x);
      end
      2'd2: begin
        t.c = -40'(r.x);
        t.s = -40'(r.y);
      end
      default: begin
        t.c = 40'(r.y);
        t.s = -40'(r.x);
      end
    endcase
    return t;
  endfunction

  // product truncated toward zero
  function automatic logic signed [39:0] mulq(input logic signed [39:0] a,
                                              input logic signed [39:0] b,
                                              input logic [5:0] sh);
    logic signed [79:0] pr;
    logic [79:0]        mg;
    logic [79:0]        r;
    logic signed [39:0] r40;
    pr  = a * b;
    mg  = pr[79] ? 80'(-pr) : 80'(pr);
    r   = mg >> sh;
    r40 = $signed(r[39:0]);
    return pr[79] ? -r40 : r40;
  endfunction

endpackage

### hw/rtl/eos_cordic_cell.sv
module eos_cordic_cell (
  input  logic          clk,
  input  logic [4:0]    stage,
  input  eos_pkg::rot_t d_in,
  output eos_pkg::rot_t d_out
);

  eos_pkg::rot_t      rot_r;
  eos_pkg::rot_t      rot_nxt;
  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [31:0] at;

  always_comb begin
    xs      = d_in.x >>> stage;
    ys      = d_in.y >>> stage;
    at      = $signed(eos_pkg::atan_turn(stage));
    rot_nxt = d_in;
    if (!d_in.z[31]) begin
      rot_nxt.x = d_in.x - ys;
      rot_nxt.y = d_in.y + xs;
      rot_nxt.z = d_in.z - at;
    end else begin
      rot_nxt.x = d_in.x + ys;
      rot_nxt.y = d_in.y - xs;
      rot_nxt.z = d_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
  end

  assign d_out = rot_r;

endmodule

### hw/rtl/eos_div_cell.sv
module eos_div_cell (
  input  logic          clk,
  input  eos_pkg::dvd_t d_in,
  output eos_pkg::dvd_t d_out
);

  eos_pkg::dvd_t dvd_r;
  eos_pkg::dvd_t dvd_nxt;
  logic [32:0]   t;
  logic [32:0]   diff;
  logic          ge;

  always_comb begin
    t       = {d_in.rem, d_in.low[31]};
    diff    = t - {1'b0, d_in.d};
    ge      = (t >= {1'b0, d_in.d});
    dvd_nxt = d_in;
    dvd_nxt.rem = ge ? diff[31:0] : t[31:0];
    dvd_nxt.low = {d_in.low[30:0], 1'b0};
    dvd_nxt.quo = {d_in.quo[30:0], ge};
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
  end

  assign d_out = dvd_r;

endmodule

### hw/rtl/eccentric_orbit_strain_sample.sv
// Throughput: one word per cycle; busy stays low, start may be high every cycle.
// The depth is set by the CORDIC rotation chain and the 32-cell divider chain.
// Results are not held back: out_valid marks each word for exactly one cycle.
// Reset (rst_n low, synchronous) drops all words in flight and restores the configuration registers.
module eccentric_orbit_strain_sample (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_semilatus,
  input  logic [31:0]        in_eccentricity,
  input  logic [31:0]        in_orbit_phase,
  output logic               out_valid,
  output logic signed [31:0] out_strain,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int CS  = eos_pkg::CORDIC_STAGES;
  localparam int NA  = eos_pkg::NUM_ANGLES;
  localparam int LAT = eos_pkg::LATENCY;
  localparam int QB  = eos_pkg::QUO_BITS;

  logic signed [31:0] cos_iota_r;
  logic [31:0]        azimuth_r;
  logic signed [31:0] plus_r;
  logic signed [31:0] cross_r;
  logic [31:0]        ref_semi_r;

  logic [LAT-1:0] vld_r;
  logic           accept;

  eos_pkg::rot_t  rchain [NA][CS+1];
  eos_pkg::dvd_t  dchain [QB+1];
  logic [31:0]    e_dl_r [CS+1];
  logic [31:0]    p_dl_r [CS+1];

  eos_pkg::trig_t trig_r [NA];
  logic [31:0]    eq_r, pq_r;

  logic signed [39:0] cc1_r, ee1_r, s5c1_r, s5s1_r, ca1_r, sa1_r, cd1_r, c2b1_r, s2b1_r, e1_r;
  logic [31:0]        p1_r;
  logic signed [39:0] s2_c, opc_c, c40;
  logic signed [39:0] topca2_r, teopc2_r, tes22_r, topc2b2_r, tcsa2_r, tec2_r, teec2_r;
  logic signed [39:0] s22_r, ee2_r, s5c2_r, s5s2_r, cd2_r, s2b2_r;
  logic [31:0]        p2_r;
  logic signed [39:0] u1_r, u2_r, u3_r, u4_r, u5_r, topca3_r, tcsa3_r;
  logic [31:0]        p3_r;
  logic signed [39:0] hp4_r, hx4_r;
  logic [31:0]        p4_r;
  logic signed [39:0] sp5_r, sx5_r;
  logic [31:0]        p5_r;
  logic signed [39:0] s20_c;
  logic [31:0]        mag6_r, p6_r;
  logic               neg6_r;
  logic [63:0]        num_c;
  logic [31:0]        b2;
  logic signed [31:0] strain_nxt;
  logic signed [31:0] strain_r;
  eos_pkg::dvd_t      dlast;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_iota_r <= 32'sh40000000;
      azimuth_r  <= '0;
      plus_r     <= '0;
      cross_r    <= '0;
      ref_semi_r <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eos_pkg::REG_COS_IOTA:       cos_iota_r <= $signed(cfg_wdata);
        eos_pkg::REG_SOURCE_AZIMUTH: azimuth_r  <= cfg_wdata;
        eos_pkg::REG_PLUS_RESPONSE:  plus_r     <= $signed(cfg_wdata);
        eos_pkg::REG_CROSS_RESPONSE: cross_r    <= $signed(cfg_wdata);
        eos_pkg::REG_REF_SEMILATUS:  ref_semi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // angles: 2f-2b, f-2b, 3f-2b, f, 2b
  assign b2 = {azimuth_r[30:0], 1'b0};

  always_ff @(posedge clk) begin
    rchain[0][0] <= eos_pkg::rot_init({in_orbit_phase[30:0], 1'b0} - b2);
    rchain[1][0] <= eos_pkg::rot_init(in_orbit_phase - b2);
    rchain[2][0] <= eos_pkg::rot_init(in_orbit_phase + {in_orbit_phase[30:0], 1'b0} - b2);
    rchain[3][0] <= eos_pkg::rot_init(in_orbit_phase);
    rchain[4][0] <= eos_pkg::rot_init(b2);
    e_dl_r[0]    <= in_eccentricity;
    p_dl_r[0]    <= in_semilatus;
    for (int i = 1; i <= CS; i++) begin
      e_dl_r[i] <= e_dl_r[i-1];
      p_dl_r[i] <= p_dl_r[i-1];
    end
  end

  for (genvar l = 0; l < NA; l++) begin : g_lane
    for (genvar i = 0; i < CS; i++) begin : g_stage
      eos_cordic_cell u_cell (
        .clk   (clk),
        .stage (5'(i)),
        .d_in  (rchain[l][i]),
        .d_out (rchain[l][i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NA; l++) begin
      trig_r[l] <= eos_pkg::rot_out(rchain[l][CS]);
    end
    eq_r <= e_dl_r[CS];
    pq_r <= p_dl_r[CS];
  end

  assign c40 = 40'(cos_iota_r);

  always_ff @(posedge clk) begin
    cc1_r  <= eos_pkg::mulq(c40, c40, 6'd30);
    ee1_r  <= eos_pkg::mulq($signed({8'b0, eq_r}), $signed({8'b0, eq_r}), 6'd31);
    s5c1_r <= (trig_r[1].c <<< 2) + trig_r[1].c + trig_r[2].c;
    s5s1_r <= (trig_r[1].s <<< 2) + trig_r[1].s + trig_r[2].s;
    ca1_r  <= trig_r[0].c;
    sa1_r  <= trig_r[0].s;
    cd1_r  <= trig_r[3].c;
    c2b1_r <= trig_r[4].c;
    s2b1_r <= trig_r[4].s;
    e1_r   <= $signed({8'b0, eq_r});
    p1_r   <= pq_r;
  end

  assign s2_c  = eos_pkg::ONE_Q30 - cc1_r;
  assign opc_c = eos_pkg::ONE_Q30 + cc1_r;

  always_ff @(posedge clk) begin
    topca2_r  <= eos_pkg::mulq(opc_c, ca1_r, 6'd30);
    teopc2_r  <= eos_pkg::mulq(e1_r, opc_c, 6'd32);
    tes22_r   <= eos_pkg::mulq(e1_r, s2_c, 6'd31);
    topc2b2_r <= eos_pkg::mulq(opc_c, c2b1_r, 6'd30);
    tcsa2_r   <= eos_pkg::mulq(c40, sa1_r, 6'd30);
    tec2_r    <= eos_pkg::mulq(e1_r, c40, 6'd31);
    teec2_r   <= eos_pkg::mulq(ee1_r, c40, 6'd31);
    s22_r     <= s2_c;
    ee2_r     <= ee1_r;
    s5c2_r    <= s5c1_r;
    s5s2_r    <= s5s1_r;
    cd2_r     <= cd1_r;
    s2b2_r    <= s2b1_r;
    p2_r      <= p1_r;
  end

  always_ff @(posedge clk) begin
    u1_r     <= eos_pkg::mulq(teopc2_r, s5c2_r, 6'd30);
    u2_r     <= eos_pkg::mulq(tes22_r, cd2_r, 6'd30);
    u3_r     <= eos_pkg::mulq(ee2_r, topc2b2_r + s22_r, 6'd31);
    u4_r     <= eos_pkg::mulq(tec2_r, s5s2_r, 6'd30);
    u5_r     <= eos_pkg::mulq(teec2_r, s2b2_r, 6'd30);
    topca3_r <= topca2_r;
    tcsa3_r  <= tcsa2_r;
    p3_r     <= p2_r;
  end

  always_ff @(posedge clk) begin
    hp4_r <= (topca3_r <<< 1) + u1_r + u2_r + u3_r;
    hx4_r <= (tcsa3_r <<< 2) + u4_r - (u5_r <<< 1);
    p4_r  <= p3_r;
  end

  always_ff @(posedge clk) begin
    sp5_r <= eos_pkg::mulq(40'(plus_r), hp4_r, 6'd40);
    sx5_r <= eos_pkg::mulq(40'(cross_r), hx4_r, 6'd40);
    p5_r  <= p4_r;
  end

  assign s20_c = sp5_r + sx5_r;

  always_ff @(posedge clk) begin
    neg6_r <= s20_c[39];
    mag6_r <= s20_c[39] ? 32'(-s20_c) : 32'(s20_c);
    p6_r   <= (p5_r == '0) ? 32'd1 : p5_r;
  end

  assign num_c = 64'(mag6_r) * 64'(ref_semi_r);

  always_ff @(posedge clk) begin
    dchain[0].rem <= num_c[63:32];
    dchain[0].low <= num_c[31:0];
    dchain[0].d   <= p6_r;
    dchain[0].quo <= '0;
    dchain[0].neg <= neg6_r;
    dchain[0].sat <= (num_c[63:32] >= p6_r);
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    eos_div_cell u_div (
      .clk   (clk),
      .d_in  (dchain[j]),
      .d_out (dchain[j+1])
    );
  end

  assign dlast = dchain[QB];

  always_comb begin
    if (dlast.neg) begin
      strain_nxt = (dlast.sat || dlast.quo > 32'h80000000) ? 32'sh80000000
                                                          : $signed(32'(-dlast.quo));
    end else begin
      strain_nxt = (dlast.sat || dlast.quo[31]) ? 32'sh7FFFFFFF : $signed(dlast.quo);
    end
  end

  always_ff @(posedge clk) begin
    strain_r <= strain_nxt;
  end

  assign out_valid  = vld_r[LAT-1];
  assign out_strain = strain_r;

  a_out_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result word without a matching start");

  a_zero_ref_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ref_semi_r == '0) |-> out_strain == '0)
    else $error("nonzero strain with zero reference semilatus");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAT-2] && !dlast.sat) |-> dlast.rem < dlast.d)
    else $error("divider remainder not below divisor");

endmodule
